// ===== sv/circ_pkg.sv =====
// shared widths, types and the midpoint step function for the circle generator
package circ_pkg;

  localparam int COORD_BITS  = 11;
  localparam int RADIUS_BITS = 10;
  localparam int PIX_W       = 13;
  // decision error magnitude stays below 2*radius + 3
  localparam int ERR_W       = RADIUS_BITS + 3;
  // dx and dy as signed values, with room for the step past the octant
  localparam int DIM_W       = RADIUS_BITS + 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int          OCT_W    = 3;
  localparam logic [OCT_W-1:0] LAST_OCT = OCT_W'(7);

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_e;

  // walker position and decision error
  typedef struct packed {
    logic signed [DIM_W-1:0] dx;
    logic signed [DIM_W-1:0] dy;
    logic signed [ERR_W-1:0] err;
  } walk_t;

  // one position to be mirrored into eight points
  typedef struct packed {
    logic [COORD_BITS-1:0]  cx;
    logic [COORD_BITS-1:0]  cy;
    logic [RADIUS_BITS-1:0] dx;
    logic [RADIUS_BITS-1:0] dy;
    logic                   done;
  } pos_t;

  // one midpoint step: dy grows, dx shrinks when the midpoint lies outside
  function automatic walk_t walk_advance(walk_t w);
    walk_t                 r;
    logic signed [ERR_W:0] e1;
    logic signed [ERR_W:0] e2;
    logic signed [ERR_W:0] dxe;
    logic signed [DIM_W-1:0] dyn;
    logic signed [DIM_W-1:0] dxn;
    dyn  = w.dy + DIM_W'(1);
    e1   = (ERR_W+1)'(w.err) + ((ERR_W+1)'(dyn) <<< 1) + (ERR_W+1)'(1);
    dxe  = (ERR_W+1)'(w.dx);
    dxn  = w.dx - DIM_W'(1);
    e2   = e1 + (ERR_W+1)'(1) - ((ERR_W+1)'(dxn) <<< 1);
    r.dy = dyn;
    // 2*(e1 - dx) + 1 > 0 is the same as e1 - dx >= 0
    if ((e1 - dxe) >= 0) begin
      r.dx  = dxn;
      r.err = e2[ERR_W-1:0];
    end else begin
      r.dx  = w.dx;
      r.err = e1[ERR_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/circ_front.sv =====
// front end: takes start and step items, walks the octant, queues positions
module circ_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  logic                             q_full_i,
  input  logic                             action_i,
  input  logic [circ_pkg::COORD_BITS-1:0]  center_x_i,
  input  logic [circ_pkg::COORD_BITS-1:0]  center_y_i,
  input  logic [circ_pkg::RADIUS_BITS-1:0] radius_i,
  output circ_pkg::pos_t                   rec_o,
  output logic                             rec_push_o
);
  import circ_pkg::*;

  logic                  active_q, active_d;
  walk_t                 next_q;
  logic [COORD_BITS-1:0] cx_q, cy_q;

  logic  accept, start, done;
  walk_t seed, cur, nxt;

  assign accept = push_i && !q_full_i;
  assign start  = (action_e'(action_i) == ACT_START);

  always_comb begin
    seed.dx  = DIM_W'(radius_i);
    seed.dy  = '0;
    seed.err = '0;
    // the position emitted now; its successor is kept for the next step
    cur      = start ? seed : next_q;
    nxt      = walk_advance(cur);
    done     = (nxt.dx < nxt.dy);
  end

  assign rec_push_o = accept && (start || active_q);

  always_comb begin
    rec_o.cx   = start ? center_x_i : cx_q;
    rec_o.cy   = start ? center_y_i : cy_q;
    rec_o.dx   = cur.dx[RADIUS_BITS-1:0];
    rec_o.dy   = cur.dy[RADIUS_BITS-1:0];
    rec_o.done = done;
    active_d   = rec_push_o ? !done : active_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_push_o) begin
      next_q <= nxt;
    end
    if (accept && start) begin
      cx_q <= center_x_i;
      cy_q <= center_y_i;
    end
  end

endmodule

// ===== sv/circ_fifo.sv =====
// short position queue between the front end and the point serializer
module circ_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  circ_pkg::pos_t wdata_i,
  input  logic           pop_i,
  output circ_pkg::pos_t rdata_o,
  output logic           full_o,
  output logic           empty_o
);
  import circ_pkg::*;

  pos_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== sv/circ_back.sv =====
// back end: mirrors queued positions into eight points, one per cycle unless stalled
module circ_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  circ_pkg::pos_t                    head_i,
  input  logic                              q_empty_i,
  output logic                              q_pop_o,
  input  logic                              pop_i,
  output logic                              empty_o,
  output logic signed [circ_pkg::PIX_W-1:0] pixel_x_o,
  output logic signed [circ_pkg::PIX_W-1:0] pixel_y_o,
  output logic                              last_o,
  output logic                              done_res_o
);
  import circ_pkg::*;

  logic [OCT_W-1:0] oct_q;
  logic             valid_q;
  logic [PIX_W-1:0] px_q, py_q;
  logic             last_q, done_q;

  logic             adv, load, swap, neg_x, neg_y;
  logic [PIX_W-1:0] cx, cy, ax, ay, px_d, py_d;

  assign adv     = !valid_q || pop_i;
  assign load    = adv && !q_empty_i;
  assign q_pop_o = load && (oct_q == LAST_OCT);

  // octant order: swap on 1,2,5,6; negate x on 2..5; negate y on 4..7
  always_comb begin
    swap  = oct_q[0] ^ oct_q[1];
    neg_x = oct_q[2] ^ oct_q[1];
    neg_y = oct_q[2];
    cx    = PIX_W'(head_i.cx);
    cy    = PIX_W'(head_i.cy);
    ax    = PIX_W'(swap ? head_i.dy : head_i.dx);
    ay    = PIX_W'(swap ? head_i.dx : head_i.dy);
    px_d  = neg_x ? cx - ax : cx + ax;
    py_d  = neg_y ? cy - ay : cy + ay;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oct_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (adv) begin
        valid_q <= !q_empty_i;
      end
      if (load) begin
        oct_q <= oct_q + OCT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      px_q   <= px_d;
      py_q   <= py_d;
      last_q <= (oct_q == LAST_OCT);
      done_q <= head_i.done;
    end
  end

  assign empty_o    = !valid_q;
  assign pixel_x_o  = $signed(px_q);
  assign pixel_y_o  = $signed(py_q);
  assign last_o     = last_q;
  assign done_res_o = done_q;

endmodule

// ===== sv/midpoint_circle_generator.sv =====
// top level of the midpoint circle outline generator
//
// input channel: an item transfers on a clock edge with push high and full
// low. action_i low starts a circle at center_x_i/center_y_i with radius_i,
// action_i high advances the current circle by one midpoint step.
// result channel: while empty is low the oldest point sits on pixel_x_o,
// pixel_y_o, last_o and done_res_o; it transfers on an edge with pop high.
// every start, and every step while a circle is active, yields eight points,
// last_o marking the eighth; done_res_o is high on all eight once no step
// remains. a step with no active circle transfers and yields nothing.
// path: with the back end idle, the first point of an item goes through the
// position queue and then the output register.
// throughput: one point per cycle out of the single output register while
// the receiver takes them; the front end takes one item per cycle while the
// two-entry position queue has room, so it walks ahead of the point stream.
// a stalled receiver holds the output register; the queue fills and full
// then holds off the sender, nothing is dropped.
// reset: queue and output empty, no circle active.
module midpoint_circle_generator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic                              action_i,
  input  logic [circ_pkg::COORD_BITS-1:0]   center_x_i,
  input  logic [circ_pkg::COORD_BITS-1:0]   center_y_i,
  input  logic [circ_pkg::RADIUS_BITS-1:0]  radius_i,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [circ_pkg::PIX_W-1:0] pixel_x_o,
  output logic signed [circ_pkg::PIX_W-1:0] pixel_y_o,
  output logic                              last_o,
  output logic                              done_res_o
);
  import circ_pkg::*;

  pos_t rec, head;
  logic rec_push, q_full, q_empty, q_pop;

  // front end walks the octant; a start reloads the walker from the inputs
  circ_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .q_full_i   (q_full),
    .action_i   (action_i),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .radius_i   (radius_i),
    .rec_o      (rec),
    .rec_push_o (rec_push)
  );

  // positions wait here while the back end serializes earlier ones
  circ_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .wdata_i (rec),
    .pop_i   (q_pop),
    .rdata_o (head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // back end mirrors each position into its eight octant points
  circ_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .pixel_x_o  (pixel_x_o),
    .pixel_y_o  (pixel_y_o),
    .last_o     (last_o),
    .done_res_o (done_res_o)
  );

  // the sender is held off only by a full position queue
  assign full = q_full;

endmodule

// ===== sv/circ_chk.sv =====
// port-level checks on the circle generator's point stream, bound to the top
module circ_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              empty,
  input logic                              pop,
  input logic signed [circ_pkg::PIX_W-1:0] pixel_x_o,
  input logic signed [circ_pkg::PIX_W-1:0] pixel_y_o,
  input logic                              last_o,
  input logic                              done_res_o
);

  // a point that is not the eighth is followed at once by the next one
  a_group_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !last_o) |=> !empty)
    else $error("point group broken by a gap");

  // all eight points of a group carry the same done flag
  a_done_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !last_o) |=> (done_res_o == $past(done_res_o)))
    else $error("done flag changed inside a point group");

  // a waiting point holds while the receiver stalls
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(pixel_x_o) && $stable(pixel_y_o)
                          && $stable(last_o)))
    else $error("waiting point changed under stall");

  // nothing can be waiting in the output right after reset ends
  a_reset_empty: assert property (@(posedge clk_i)
    (!rst_ni) |=> (empty || !rst_ni))
    else $error("output not empty after reset");

endmodule

bind midpoint_circle_generator circ_chk u_circ_chk (.*);
